// File: rtl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared constants, command codes, word offsets, item types and field
// helpers for the GPIO register block.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam int NUM_PINS  = 54;             // pins present, 1..64
  localparam int PIN_W     = NUM_PINS;       // width of per-pin state words
  localparam int OUT_W     = 54;             // width of per-pin result fields
  localparam int FSEL_WORDS = 6;
  localparam int FSEL_W    = 30;
  localparam int FSEL_PER_WORD = 10;
  localparam int FSEL_PINS = FSEL_WORDS * FSEL_PER_WORD;
  localparam int PULL_WORDS = 4;
  localparam int PULL_W    = 32;
  localparam int PULL_PER_WORD = 16;
  localparam int CMD_W     = 2;
  localparam int WIDX_W    = 6;
  localparam int DATA_W    = 32;

  localparam logic [2:0] FSEL_OUT = 3'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SAMPLE = 2'd2
  } gpr_cmd_t;

  // register word offsets
  localparam logic [WIDX_W-1:0] W_FSEL0 = 6'd0;
  localparam logic [WIDX_W-1:0] W_FSEL5 = 6'd5;
  localparam logic [WIDX_W-1:0] W_SET0  = 6'd7;
  localparam logic [WIDX_W-1:0] W_SET1  = 6'd8;
  localparam logic [WIDX_W-1:0] W_CLR0  = 6'd10;
  localparam logic [WIDX_W-1:0] W_CLR1  = 6'd11;
  localparam logic [WIDX_W-1:0] W_LEV0  = 6'd13;
  localparam logic [WIDX_W-1:0] W_LEV1  = 6'd14;
  localparam logic [WIDX_W-1:0] W_EDS0  = 6'd16;
  localparam logic [WIDX_W-1:0] W_EDS1  = 6'd17;
  localparam logic [WIDX_W-1:0] W_REN0  = 6'd19;
  localparam logic [WIDX_W-1:0] W_REN1  = 6'd20;
  localparam logic [WIDX_W-1:0] W_FEN0  = 6'd22;
  localparam logic [WIDX_W-1:0] W_FEN1  = 6'd23;
  localparam logic [WIDX_W-1:0] W_HEN0  = 6'd25;
  localparam logic [WIDX_W-1:0] W_HEN1  = 6'd26;
  localparam logic [WIDX_W-1:0] W_LEN0  = 6'd28;
  localparam logic [WIDX_W-1:0] W_LEN1  = 6'd29;
  localparam logic [WIDX_W-1:0] W_PULL0 = 6'd57;
  localparam logic [WIDX_W-1:0] W_PULL3 = 6'd60;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WIDX_W-1:0] word_index;
    logic [DATA_W-1:0] write_data;
    logic [OUT_W-1:0]  pin_levels;
  } gpr_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [OUT_W-1:0]  drive_levels;
    logic [OUT_W-1:0]  drive_enable;
    logic              event_pending;
  } gpr_result_t;

  // field bits of present pins in function select word k
  function automatic logic [FSEL_W-1:0] fsel_mask(input int k);
    logic [FSEL_W-1:0] m;
    m = '0;
    for (int f = 0; f < FSEL_PER_WORD; f++) begin
      if (k * FSEL_PER_WORD + f < NUM_PINS) m[3*f +: 3] = 3'b111;
    end
    return m;
  endfunction

  // field bits of present pins in pull select word k
  function automatic logic [PULL_W-1:0] pull_mask(input int k);
    logic [PULL_W-1:0] m;
    m = '0;
    for (int f = 0; f < PULL_PER_WORD; f++) begin
      if (k * PULL_PER_WORD + f < NUM_PINS) m[2*f +: 2] = 2'b11;
    end
    return m;
  endfunction

  // data placed in the low or high 32-pin half, limited to present pins
  function automatic logic [PIN_W-1:0] half_bits(input logic hi, input logic [31:0] d);
    logic [63:0] v;
    v = hi ? {d, 32'h0} : {32'h0, d};
    return v[PIN_W-1:0];
  endfunction

  function automatic logic [31:0] half_read(input logic [PIN_W-1:0] r, input logic hi);
    logic [63:0] v;
    v = 64'(r);
    return hi ? v[63:32] : v[31:0];
  endfunction

  function automatic logic [PIN_W-1:0] half_write(input logic [PIN_W-1:0] r, input logic hi,
                                                  input logic [31:0] d);
    logic [63:0] v;
    v = 64'(r);
    v = hi ? {32'h0, v[31:0]} : {v[63:32], 32'h0};
    return v[PIN_W-1:0] | half_bits(hi, d);
  endfunction

endpackage

// File: rtl/gpr_if.sv
// ----------------------------------------------------------------------------
// gpr_in_if / gpr_out_if
// Valid/ready channels for bus and sample items and for result items.
// ----------------------------------------------------------------------------
interface gpr_in_if;
  logic                        valid;
  logic                        ready;
  logic [gpr_pkg::CMD_W-1:0]   cmd;
  logic [gpr_pkg::WIDX_W-1:0]  word_index;
  logic [gpr_pkg::DATA_W-1:0]  write_data;
  logic [gpr_pkg::OUT_W-1:0]   pin_levels;

  modport source (output valid, cmd, word_index, write_data, pin_levels, input ready);
  modport sink   (input valid, cmd, word_index, write_data, pin_levels, output ready);
endinterface

interface gpr_out_if;
  logic                        valid;
  logic                        ready;
  logic [gpr_pkg::DATA_W-1:0]  read_data;
  logic [gpr_pkg::OUT_W-1:0]   drive_levels;
  logic [gpr_pkg::OUT_W-1:0]   drive_enable;
  logic                        event_pending;

  modport source (output valid, read_data, drive_levels, drive_enable, event_pending,
                  input ready);
  modport sink   (input valid, read_data, drive_levels, drive_enable, event_pending,
                  output ready);
endinterface

// File: rtl/gpr_regfile.sv
// ----------------------------------------------------------------------------
// gpr_regfile
// Register state, bus read/write decode, pin sampling with event detect,
// and the result item computed from the state after the update.
// ----------------------------------------------------------------------------
module gpr_regfile (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  gpr_pkg::gpr_item_t  item,
  output gpr_pkg::gpr_result_t result
);
  import gpr_pkg::*;

  logic [FSEL_W-1:0] fsel_r   [FSEL_WORDS];
  logic [FSEL_W-1:0] fsel_nxt [FSEL_WORDS];
  logic [PULL_W-1:0] pull_r   [PULL_WORDS];
  logic [PULL_W-1:0] pull_nxt [PULL_WORDS];
  logic [PIN_W-1:0]  latch_r, latch_nxt;
  logic [PIN_W-1:0]  status_r, status_nxt;
  logic [PIN_W-1:0]  rise_r, rise_nxt;
  logic [PIN_W-1:0]  fall_r, fall_nxt;
  logic [PIN_W-1:0]  high_r, high_nxt;
  logic [PIN_W-1:0]  low_r, low_nxt;
  logic [PIN_W-1:0]  level_r, level_nxt;

  logic [WIDX_W-1:0] w;
  logic [31:0]       d;
  logic [2:0]        fidx;
  logic [1:0]        pidx;
  logic [PIN_W-1:0]  cur, hit;
  logic [DATA_W-1:0] rd;
  logic [OUT_W-1:0]  den;

  assign w         = item.word_index;
  assign d         = item.write_data;
  assign fidx      = w[2:0];
  assign pidx      = 2'(w - W_PULL0);
  assign cur       = PIN_W'(64'(item.pin_levels));
  assign hit       = (~level_r & cur & rise_r) | (level_r & ~cur & fall_r)
                   | (cur & high_r) | (~cur & low_r);

  always_comb begin
    fsel_nxt   = fsel_r;
    pull_nxt   = pull_r;
    latch_nxt  = latch_r;
    status_nxt = status_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    high_nxt   = high_r;
    low_nxt    = low_r;
    level_nxt  = level_r;
    rd         = '0;
    if (accept) begin
      unique case (item.cmd)
        CMD_READ: begin
          if (w <= W_FSEL5) begin
            rd = 32'(fsel_r[fidx] & fsel_mask(int'(fidx)));
          end else if (w >= W_PULL0 && w <= W_PULL3) begin
            rd = pull_r[pidx] & pull_mask(int'(pidx));
          end else begin
            unique case (w) inside
              W_LEV0, W_LEV1: rd = half_read(level_r, w == W_LEV1);
              W_EDS0, W_EDS1: rd = half_read(status_r, w == W_EDS1);
              W_REN0, W_REN1: rd = half_read(rise_r, w == W_REN1);
              W_FEN0, W_FEN1: rd = half_read(fall_r, w == W_FEN1);
              W_HEN0, W_HEN1: rd = half_read(high_r, w == W_HEN1);
              W_LEN0, W_LEN1: rd = half_read(low_r, w == W_LEN1);
              default:        rd = '0;
            endcase
          end
        end
        CMD_WRITE: begin
          if (w <= W_FSEL5) begin
            fsel_nxt[fidx] = d[FSEL_W-1:0] & fsel_mask(int'(fidx));
          end else if (w >= W_PULL0 && w <= W_PULL3) begin
            pull_nxt[pidx] = d & pull_mask(int'(pidx));
          end else begin
            unique case (w) inside
              W_SET0, W_SET1: latch_nxt  = latch_r | half_bits(w == W_SET1, d);
              W_CLR0, W_CLR1: latch_nxt  = latch_r & ~half_bits(w == W_CLR1, d);
              W_EDS0, W_EDS1: status_nxt = status_r & ~half_bits(w == W_EDS1, d);
              W_REN0, W_REN1: rise_nxt   = half_write(rise_r, w == W_REN1, d);
              W_FEN0, W_FEN1: fall_nxt   = half_write(fall_r, w == W_FEN1, d);
              W_HEN0, W_HEN1: high_nxt   = half_write(high_r, w == W_HEN1, d);
              W_LEN0, W_LEN1: low_nxt    = half_write(low_r, w == W_LEN1, d);
              default: ;
            endcase
          end
        end
        CMD_SAMPLE: begin
          level_nxt  = cur;
          status_nxt = status_r | hit;
        end
        default: ;
      endcase
    end
  end

  // output function code per pin, from the updated select words
  always_comb begin
    den = '0;
    for (int p = 0; p < OUT_W; p++) begin
      if (p < NUM_PINS && p < FSEL_PINS) begin
        den[p] = (fsel_nxt[p / FSEL_PER_WORD][3 * (p % FSEL_PER_WORD) +: 3] == FSEL_OUT);
      end
    end
  end

  always_comb begin
    result.read_data     = rd;
    result.drive_levels  = OUT_W'(64'(latch_nxt));
    result.drive_enable  = den;
    result.event_pending = |status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FSEL_WORDS; i++) fsel_r[i] <= '0;
      for (int i = 0; i < PULL_WORDS; i++) pull_r[i] <= '0;
      latch_r  <= '0;
      status_r <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
      high_r   <= '0;
      low_r    <= '0;
      level_r  <= '0;
    end else begin
      fsel_r   <= fsel_nxt;
      pull_r   <= pull_nxt;
      latch_r  <= latch_nxt;
      status_r <= status_nxt;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      high_r   <= high_nxt;
      low_r    <= low_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

// File: rtl/gpr_out_stage.sv
// ----------------------------------------------------------------------------
// gpr_out_stage
// Result register: holds one result item and takes the next one in the
// cycle the waiting item is taken.
// ----------------------------------------------------------------------------
module gpr_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  gpr_pkg::gpr_result_t result,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 can_load,
  output gpr_pkg::gpr_result_t out_data
);
  import gpr_pkg::*;

  logic        valid_r, valid_nxt;
  gpr_result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: hold while stalled, advance on load
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

// File: rtl/gpio_register_block.sv
// ----------------------------------------------------------------------------
// gpio_register_block
// GPIO register block: bus reads and writes of the register map, pin level
// sampling with edge and level event detect, one result item per item.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                              handshake
//  in_ch    in   cmd, word_index, write_data, pin_levels              valid/ready
//  out_ch   out  read_data, drive_levels, drive_enable, event_pending valid/ready
//
//  One item per cycle while out_ch is not stalled; its result is registered and appears in the cycle after acceptance.
//  Latency and throughput are set by the single result register: decode,
//  state update and result forming all happen in the accept cycle.
//  Reset (synchronous, active low) clears all state registers and the result valid; the result payload is not reset.
//  in_ch.ready stays high while out_ch is stalled only if the result register
//  is empty; otherwise it follows out_ch.ready.
// ----------------------------------------------------------------------------
module gpio_register_block (
  input  logic             clk,
  input  logic             rst_n,
  gpr_in_if.sink           in_ch,
  gpr_out_if.source        out_ch
);
  import gpr_pkg::*;

  logic        accept;
  logic        can_load;
  gpr_item_t   item;
  gpr_result_t result;
  gpr_result_t out_data;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  always_comb begin
    item.cmd        = in_ch.cmd;
    item.word_index = in_ch.word_index;
    item.write_data = in_ch.write_data;
    item.pin_levels = in_ch.pin_levels;
  end

  gpr_regfile u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .result (result)
  );

  gpr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .result    (result),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .can_load  (can_load),
    .out_data  (out_data)
  );

  assign out_ch.read_data     = out_data.read_data;
  assign out_ch.drive_levels  = out_data.drive_levels;
  assign out_ch.drive_enable  = out_data.drive_enable;
  assign out_ch.event_pending = out_data.event_pending;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gpio_register_block. A queue of bus reads, bus
// writes and pin samples feeds a valid/ready driver; each accepted item also
// updates an in-bench copy of the register state, which yields the expected
// result item. The monitor stalls at random and checks every result field.
// ----------------------------------------------------------------------------
module testbench;
  import gpr_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int MAX_WAIT     = 12;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int W_HOLE_FSEL = 6;   // unmapped word right after the function selects
  localparam int W_LAST      = 63;  // unmapped word at the top of the map

  // detect enable kinds, in word order
  localparam int DET_RISE = 0;
  localparam int DET_FALL = 1;
  localparam int DET_HIGH = 2;
  localparam int DET_LOW  = 3;

  localparam logic [63:0] PIN_PRESENT = (64'd1 << NUM_PINS) - 64'd1;

  logic clk;
  logic rst_n;

  gpr_in_if  in_bus ();
  gpr_out_if out_bus ();

  gpio_register_block u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // register state as the bench sees it
  logic [FSEL_W-1:0] fsel_q [FSEL_WORDS];
  logic [PULL_W-1:0] pull_q [PULL_WORDS];
  logic [63:0]       latch_q;
  logic [63:0]       status_q;
  logic [63:0]       prev_lev_q;
  logic [63:0]       cur_lev_q;
  logic [63:0]       detect_en_q [4];

  gpr_item_t   pending_items [$];
  gpr_result_t expected_snapshots [$];
  gpr_item_t   sent_item;

  int send_gap;
  int recv_hold;
  bit send_quiet;
  bit recv_quiet;
  int fault_count;
  int results_checked;
  int events_seen;
  int cmd_seen [4];
  int cycle_count;

  // --------------------------------------------------------------------------
  // state update and expected result
  // --------------------------------------------------------------------------
  function automatic logic [FSEL_W-1:0] fsel_keep(input int k);
    logic [FSEL_W-1:0] m;
    m = '0;
    for (int f = 0; f < FSEL_PER_WORD; f++) begin
      if (k * FSEL_PER_WORD + f < NUM_PINS) m[3*f +: 3] = 3'b111;
    end
    return m;
  endfunction

  function automatic logic [PULL_W-1:0] pull_keep(input int k);
    logic [PULL_W-1:0] m;
    m = '0;
    for (int f = 0; f < PULL_PER_WORD; f++) begin
      if (k * PULL_PER_WORD + f < NUM_PINS) m[2*f +: 2] = 2'b11;
    end
    return m;
  endfunction

  function automatic logic [63:0] to_half(input bit hi, input logic [31:0] d);
    return (hi ? {d, 32'h0} : {32'h0, d}) & PIN_PRESENT;
  endfunction

  function automatic logic [31:0] from_half(input logic [63:0] r, input bit hi);
    return hi ? r[63:32] : r[31:0];
  endfunction

  // rise/fall/high/low words come in pairs spaced three apart
  function automatic bit is_detect_word(input int w);
    return w >= W_REN0 && w <= W_LEN1 && (w - W_REN0) % 3 != 2;
  endfunction

  function automatic logic [31:0] read_word(input int w);
    if (w <= W_FSEL5) return 32'(fsel_q[w]);
    if (w == W_LEV0 || w == W_LEV1) return from_half(cur_lev_q, w == W_LEV1);
    if (w == W_EDS0 || w == W_EDS1) return from_half(status_q, w == W_EDS1);
    if (is_detect_word(w)) return from_half(detect_en_q[(w - W_REN0) / 3], (w - W_REN0) % 3 == 1);
    if (w >= W_PULL0 && w <= W_PULL3) return pull_q[w - W_PULL0];
    return '0;
  endfunction

  function automatic void write_word(input int w, input logic [31:0] d);
    int          k;
    bit          hi;
    logic [63:0] old;
    if (w <= W_FSEL5) begin
      fsel_q[w] = d[FSEL_W-1:0] & fsel_keep(w);
    end else if (w == W_SET0 || w == W_SET1) begin
      latch_q |= to_half(w == W_SET1, d);
    end else if (w == W_CLR0 || w == W_CLR1) begin
      latch_q &= ~to_half(w == W_CLR1, d);
    end else if (w == W_EDS0 || w == W_EDS1) begin
      status_q &= ~to_half(w == W_EDS1, d);
    end else if (is_detect_word(w)) begin
      k = (w - W_REN0) / 3;
      hi = (w - W_REN0) % 3 == 1;
      old = detect_en_q[k];
      detect_en_q[k] = (hi ? {32'h0, old[31:0]} : {old[63:32], 32'h0}) | to_half(hi, d);
    end else if (w >= W_PULL0 && w <= W_PULL3) begin
      pull_q[w - W_PULL0] = d & pull_keep(w - W_PULL0);
    end
  endfunction

  function automatic gpr_result_t gpio_update(input gpr_item_t it);
    gpr_result_t r;
    logic [63:0] lev;
    logic [63:0] hit;
    logic [63:0] drv_en;
    r = '0;
    drv_en = '0;
    case (it.cmd)
      CMD_READ:  r.read_data = read_word(it.word_index);
      CMD_WRITE: write_word(it.word_index, it.write_data);
      CMD_SAMPLE: begin
        lev = 64'(it.pin_levels) & PIN_PRESENT;
        hit = (~cur_lev_q & lev & detect_en_q[DET_RISE])
            | (cur_lev_q & ~lev & detect_en_q[DET_FALL])
            | (lev & detect_en_q[DET_HIGH])
            | (~lev & detect_en_q[DET_LOW]);
        prev_lev_q = cur_lev_q;
        cur_lev_q  = lev;
        status_q  |= hit & PIN_PRESENT;
      end
      default: ;
    endcase
    for (int p = 0; p < NUM_PINS && p < FSEL_PINS && p < OUT_W; p++) begin
      if (fsel_q[p / FSEL_PER_WORD][3*(p % FSEL_PER_WORD) +: 3] == FSEL_OUT) drv_en[p] = 1'b1;
    end
    r.drive_levels  = latch_q[OUT_W-1:0];
    r.drive_enable  = drv_en[OUT_W-1:0];
    r.event_pending = |(status_q & PIN_PRESENT);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic gpr_item_t make_item(input logic [CMD_W-1:0] cmd, input int w,
                                          input logic [31:0] d, input logic [OUT_W-1:0] lev);
    gpr_item_t it;
    it.cmd        = cmd;
    it.word_index = WIDX_W'(w);
    it.write_data = d;
    it.pin_levels = lev;
    return it;
  endfunction

  function automatic logic [OUT_W-1:0] rand_pins();
    return OUT_W'({$urandom, $urandom});
  endfunction

  function automatic int pick_word();
    case ($urandom_range(0, 11))
      1, 2:    return W_FSEL0 + $urandom_range(0, FSEL_WORDS - 1);
      3:       return W_SET0 + $urandom_range(0, 1);
      4:       return W_CLR0 + $urandom_range(0, 1);
      5:       return W_LEV0 + $urandom_range(0, 1);
      6, 7:    return W_EDS0 + $urandom_range(0, 1);
      8, 9:    return $urandom_range(W_REN0, W_LEN1);
      10:      return W_PULL0 + $urandom_range(0, PULL_WORDS - 1);
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [31:0] pick_data(input int w);
    logic [31:0] d;
    d = $urandom;
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = '1;
      default: begin
        if (w <= W_FSEL5) begin
          // lean toward output function so drive enables toggle
          for (int f = 0; f < FSEL_PER_WORD; f++) begin
            if ($urandom_range(0, 2) == 0) d[3*f +: 3] = FSEL_OUT;
          end
        end else if (is_detect_word(w) || w == W_EDS0 || w == W_EDS1) begin
          // sparse, so event status neither floods nor drains at once
          d = d & $urandom & $urandom;
        end
      end
    endcase
    return d;
  endfunction

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = !quiet;
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.cmd         = '0;
    in_bus.word_index  = '0;
    in_bus.write_data  = '0;
    in_bus.pin_levels  = '0;
    out_bus.ready      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver: present queued items, update the state copy on each accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    int gap;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap     <= 0;
      for (int i = 0; i < FSEL_WORDS; i++) fsel_q[i] = '0;
      for (int i = 0; i < PULL_WORDS; i++) pull_q[i] = '0;
      for (int i = 0; i < 4; i++) detect_en_q[i] = '0;
      latch_q    = '0;
      status_q   = '0;
      prev_lev_q = '0;
      cur_lev_q  = '0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) begin
        expected_snapshots.push_back(gpio_update(sent_item));
        cmd_seen[sent_item.cmd]++;
        gap = draw_wait(send_quiet);
      end else begin
        gap = send_gap;
      end
      if (gap == 0 && pending_items.size() != 0) begin
        sent_item = pending_items.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.cmd        <= sent_item.cmd;
        in_bus.word_index <= sent_item.word_index;
        in_bus.write_data <= sent_item.write_data;
        in_bus.pin_levels <= sent_item.pin_levels;
      end else begin
        in_bus.valid <= 1'b0;
        send_gap     <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure, compare each result with the oldest
  // expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    gpr_result_t want;
    int          n;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_hold     <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      if (expected_snapshots.size() == 0) begin
        if (fault_count < REPORT_LIMIT)
          $display("[%0t] result item with nothing outstanding: rd=%h", $time,
                   out_bus.read_data);
        fault_count++;
      end else begin
        want = expected_snapshots.pop_front();
        if (out_bus.read_data !== want.read_data || out_bus.drive_levels !== want.drive_levels
            || out_bus.drive_enable !== want.drive_enable
            || out_bus.event_pending !== want.event_pending) begin
          if (fault_count < REPORT_LIMIT) begin
            $display("[%0t] mismatch on result %0d", $time, results_checked);
            $display("  read_data     exp %h got %h", want.read_data, out_bus.read_data);
            $display("  drive_levels  exp %h got %h", want.drive_levels, out_bus.drive_levels);
            $display("  drive_enable  exp %h got %h", want.drive_enable, out_bus.drive_enable);
            $display("  event_pending exp %b got %b", want.event_pending, out_bus.event_pending);
          end
          fault_count++;
        end
        if (want.event_pending) events_seen++;
        results_checked++;
      end
      n = draw_wait(recv_quiet);
      out_bus.ready <= (n == 0);
      recv_hold     <= n;
    end else if (!out_bus.ready) begin
      if (recv_hold <= 1) out_bus.ready <= 1'b1;
      if (recv_hold > 0) recv_hold <= recv_hold - 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [OUT_W-1:0] last_lev;
    logic [OUT_W-1:0] lev;
    logic [CMD_W-1:0] cmd;
    int               w;
    int               roll;
    int               waited;

    // reset values, every word kind, absent pins, ignored writes, edges
    pending_items.push_back(make_item(CMD_READ,   W_FSEL0, '0, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_FSEL0, 32'h0924_9249, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_FSEL5, '1, '0));
    pending_items.push_back(make_item(CMD_READ,   W_FSEL5, '0, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_SET0,  '1, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_SET1,  '1, '0));
    pending_items.push_back(make_item(CMD_READ,   W_SET1,  '0, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_CLR0,  32'h5555_5555, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_LEV1,  '1, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_REN0,  '1, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_FEN1,  '1, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_HEN1,  32'h0030_0000, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_LEN0,  32'h0000_0001, '0));
    pending_items.push_back(make_item(CMD_SAMPLE, W_FSEL0, '0, '1));
    pending_items.push_back(make_item(CMD_READ,   W_LEV0,  '0, '0));
    pending_items.push_back(make_item(CMD_READ,   W_LEV1,  '0, '0));
    pending_items.push_back(make_item(CMD_SAMPLE, W_FSEL0, '0, '0));
    pending_items.push_back(make_item(CMD_READ,   W_EDS0,  '0, '0));
    pending_items.push_back(make_item(CMD_READ,   W_EDS1,  '0, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_EDS0,  '1, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_EDS1,  '1, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_PULL0, '1, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_PULL3, '1, '0));
    pending_items.push_back(make_item(CMD_READ,   W_PULL3, '0, '0));
    pending_items.push_back(make_item(CMD_READ,   W_LAST,  '0, '0));
    pending_items.push_back(make_item(CMD_WRITE,  W_HOLE_FSEL, '1, '0));
    pending_items.push_back(make_item(CMD_UNUSED, W_SET0,  '1, '1));

    last_lev = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 38)      cmd = CMD_WRITE;
      else if (roll < 70) cmd = CMD_READ;
      else if (roll < 95) cmd = CMD_SAMPLE;
      else                cmd = CMD_UNUSED;
      w = pick_word();
      case ($urandom_range(0, 9))
        0:       lev = '0;
        1:       lev = '1;
        2, 3:    lev = rand_pins();
        default: lev = last_lev ^ (rand_pins() & rand_pins() & rand_pins());
      endcase
      if (cmd == CMD_SAMPLE) last_lev = lev;
      pending_items.push_back(make_item(cmd, w, pick_data(w), lev));
    end

    do @(posedge clk); while (pending_items.size() != 0 || in_bus.valid);
    waited = 0;
    while (expected_snapshots.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_snapshots.size() != 0) begin
      $display("%0d expected result items never arrived", expected_snapshots.size());
      fault_count += expected_snapshots.size();
    end

    $display("items sent: %0d reads, %0d writes, %0d samples, %0d unused-command",
             cmd_seen[CMD_READ], cmd_seen[CMD_WRITE], cmd_seen[CMD_SAMPLE], cmd_seen[CMD_UNUSED]);
    $display("results checked: %0d, %0d with an event pending, %0d faults",
             results_checked, events_seen, fault_count);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gpr_pkg.sv
rtl/gpr_if.sv
rtl/gpr_regfile.sv
rtl/gpr_out_stage.sv
rtl/gpio_register_block.sv
verif/testbench.sv
